// File: sv/lss_pkg.sv
// shared types and constants for the lifo stack with search
package lss_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_COUNT  = 3'd3,
    REQ_SEARCH = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         count;
  } rsp_t;

endpackage

// File: sv/lifo_stack_with_search.sv
// top level of the lifo stack with push, pop, peek, count, search and clear
//
//   channel  signals                      direction  payload
//   req      req_valid req_stall req_data in         lss_pkg::req_t
//   rsp      rsp_valid rsp_stall rsp_data out        lss_pkg::rsp_t
//
// one transaction at a time; push, count, clear and error cases finish in S_EXEC,
// pop and peek go on to S_RDWAIT for one memory read, search steps through S_SCAN
// from the top entry down to the match or the fill level, one memory read per entry scanned
// the result register lets a new transaction enter while a result waits
// rst clears the fill level and control; storage contents are not cleared
// a stalled result holds the finished transaction in its last state
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lss_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lss_pkg::rsp_t rsp_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lss_pkg::state_t state, state_next;
  logic [CW-1:0]   fill, fill_next;
  lss_pkg::req_t   req, req_next;
  logic [CW-1:0]   cur_pos, cur_pos_next;
  logic [AW-1:0]   scan_addr, scan_addr_next;
  logic            rsp_valid_next;
  lss_pkg::rsp_t   rsp_next;

  logic                              wr_en;
  logic                              wr_req;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [lss_pkg::DATA_W-1:0] rd_data;
  logic [AW-1:0]                     top_addr;
  logic                              rsp_free;
  logic                              done;
  lss_pkg::status_t                  res_status;
  logic signed [lss_pkg::DATA_W-1:0] res_data;
  logic [CW-1:0]                     res_pos;
  logic [CW-1:0]                     fill_after;
  logic                              is_empty;
  logic                              is_full;

  lss_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(fill)),
    .wr_data (req.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_stall = (state != lss_pkg::S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign top_addr  = AW'(fill - CW'(1));
  assign is_empty  = (fill == '0);
  assign is_full   = (fill == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lss_pkg::S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    cur_pos   <= cur_pos_next;
    scan_addr <= scan_addr_next;
    rsp_data  <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    req_next       = req;
    cur_pos_next   = cur_pos;
    scan_addr_next = scan_addr;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp_data;
    rd_en          = 1'b0;
    rd_addr        = top_addr;
    wr_req         = 1'b0;
    done           = 1'b0;
    res_status     = lss_pkg::ST_OK;
    res_data       = '0;
    res_pos        = '0;
    fill_after     = fill;

    case (state)
      lss_pkg::S_IDLE: begin
        if (req_valid) begin
          req_next   = req_data;
          state_next = lss_pkg::S_EXEC;
        end
      end
      lss_pkg::S_EXEC: begin
        case (req.req_type)
          lss_pkg::REQ_PUSH: begin
            done = 1'b1;
            if (is_full) begin
              res_status = lss_pkg::ST_FULL;
            end else begin
              wr_req     = 1'b1;
              fill_after = fill + CW'(1);
            end
          end
          lss_pkg::REQ_POP, lss_pkg::REQ_PEEK: begin
            if (is_empty) begin
              done       = 1'b1;
              res_status = lss_pkg::ST_EMPTY;
            end else begin
              rd_en      = 1'b1;
              state_next = lss_pkg::S_RDWAIT;
            end
          end
          lss_pkg::REQ_COUNT: begin
            done = 1'b1;
            if (is_empty) begin
              res_status = lss_pkg::ST_EMPTY;
            end
          end
          lss_pkg::REQ_SEARCH: begin
            if (is_empty) begin
              done       = 1'b1;
              res_status = lss_pkg::ST_EMPTY;
            end else begin
              rd_en          = 1'b1;
              cur_pos_next   = CW'(1);
              scan_addr_next = AW'(fill - CW'(2));
              state_next     = lss_pkg::S_SCAN;
            end
          end
          lss_pkg::REQ_CLEAR: begin
            done       = 1'b1;
            fill_after = '0;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      lss_pkg::S_RDWAIT: begin
        done     = 1'b1;
        res_data = rd_data;
        if (req.req_type == lss_pkg::REQ_POP) begin
          fill_after = fill - CW'(1);
        end
      end
      lss_pkg::S_SCAN: begin
        if (rd_data == req.value) begin
          done    = 1'b1;
          res_pos = cur_pos;
        end else if (cur_pos == fill) begin
          done       = 1'b1;
          res_status = lss_pkg::ST_NOTFOUND;
        end else begin
          rd_en          = 1'b1;
          rd_addr        = scan_addr;
          scan_addr_next = scan_addr - AW'(1);
          cur_pos_next   = cur_pos + CW'(1);
        end
      end
      default: begin
        state_next = lss_pkg::S_IDLE;
      end
    endcase

    // commit state change and result only when the result register is free
    if (done && rsp_free) begin
      fill_next         = fill_after;
      rsp_valid_next    = 1'b1;
      rsp_next.status   = res_status;
      rsp_next.data     = res_data;
      rsp_next.position = lss_pkg::POS_W'(res_pos);
      rsp_next.count    = lss_pkg::POS_W'(fill_after);
      state_next        = lss_pkg::S_IDLE;
    end

    wr_en = wr_req && done && rsp_free;
  end

endmodule

// File: sv/lss_ram.sv
// single write port, single registered read port stack storage
module lss_ram #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic signed [lss_pkg::DATA_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic signed [lss_pkg::DATA_W-1:0] rd_data
);

  logic signed [lss_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
